FILE: hw/rtl/kst_pkg.sv
// Shared constants and types for the key slot table with epochs.
package kst_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int KEY_BITS   = 16;

    localparam int SLOT_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int KEY_IN_W = 16;
    localparam int KEY_W    = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int CMD_W    = 2;
    localparam int SEL_W    = 4;
    localparam int IDX_W    = 5;
    localparam int EPOCH_W  = 32;

    localparam int S_TDATA_W = ((KEY_IN_W + SEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((IDX_W + EPOCH_W + 7) / 8) * 8;

    // Slot index reported when no slot applies.
    localparam logic [IDX_W-1:0] NONE_CODE = IDX_W'(SLOT_COUNT);

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE     = 2'd0,
        CMD_RELEASE     = 2'd1,
        CMD_RELEASE_ALL = 2'd2,
        CMD_READ_EPOCH  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_INSTALL = 5'b00010,
        S_SCAN    = 5'b00100,
        S_CLAIM   = 5'b01000,
        S_DONE    = 5'b10000
    } t_state;

endpackage

FILE: hw/rtl/key_slot_table_with_epochs_top.sv
// Key slot table with per-slot epochs: sequencer, slot storage and output register.
//
// The block keeps SLOT_COUNT key slots, each with a used bit, a key and a 32-bit
// epoch. Commands arrive as stream transfers: acquire, release, release-all and
// epoch read. Slot 0 holds the default key and is set up by the first acquire,
// release or release-all. One command is worked at a time and the input is not
// ready until its result has been placed in the output register. A single key
// comparator walks the table one slot per cycle, and one epoch incrementer serves
// both the slot 0 install and the claim of a free slot. An acquire goes through
// install, scan and, with no match but a free slot, claim; a release through install
// and, unless its key is the default, scan; a release-all through install; an epoch
// read goes straight to done. The input may take a new command while a finished
// result still waits at the output. The user must write the default key through the
// configuration port only while the block is idle; the block does not enforce this.
module key_slot_table_with_epochs_top
    import kst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [KEY_IN_W-1:0]  i_cfg_wdata,     // default_key

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,    // [15:0] key, [19:16] slot_select
    input  logic [CMD_W-1:0]     s_axis_tuser,    // [1:0] command

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,    // [4:0] slot_index, [36:5] epoch_value
    output logic                 m_axis_tuser     // [0] acquired
);

    // Configuration and per-slot storage.
    logic [KEY_IN_W-1:0] r_dflt;
    logic                r_used  [SLOT_COUNT];
    logic [KEY_W-1:0]    r_keys  [SLOT_COUNT];
    logic [EPOCH_W-1:0]  r_epoch [SLOT_COUNT];

    // Command in progress.
    t_state              r_state, n_state;
    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic                r_sel_ok;
    logic                r_free_vld, n_free_vld;
    logic [SLOT_W-1:0]   r_free, n_free;
    logic                r_res_acq, n_res_acq;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;

    // Output register.
    logic                r_m_valid, n_m_valid;
    logic                r_m_acq;
    logic [IDX_W-1:0]    r_m_idx;
    logic [EPOCH_W-1:0]  r_m_ep;

    logic                w_accept;
    logic                w_load_out;
    logic                w_hit;
    logic                w_last;
    logic                w_free_here;
    logic [EPOCH_W-1:0]  w_ep_inc;
    logic [EPOCH_W-1:0]  w_ep_next;
    logic [EPOCH_W-1:0]  w_out_ep;
    logic                we_install;
    logic                we_claim;
    logic                we_free;
    logic                we_clear_all;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_acq;
    assign m_axis_tdata  = M_TDATA_W'({r_m_ep, r_m_idx});

    // The single comparator looks at the slot under the scan pointer.
    assign w_hit       = r_used[r_idx] && (r_keys[r_idx] == r_key);
    assign w_last      = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign w_free_here = !r_used[r_idx] && (r_idx != '0) && !r_free_vld;

    // Shared epoch incrementer; the epoch skips zero when it wraps.
    assign w_ep_inc  = r_epoch[r_idx] + 1'b1;
    assign w_ep_next = (w_ep_inc == '0) ? EPOCH_W'(1) : w_ep_inc;

    assign w_out_ep   = ((r_cmd == CMD_READ_EPOCH) && r_sel_ok) ? r_epoch[r_idx] : '0;
    assign w_load_out = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_free_vld   = r_free_vld;
        n_free       = r_free;
        n_res_acq    = r_res_acq;
        n_res_idx    = r_res_idx;
        we_install   = 1'b0;
        we_claim     = 1'b0;
        we_free      = 1'b0;
        we_clear_all = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_free_vld = 1'b0;
                    n_free     = '0;
                    n_res_acq  = 1'b0;
                    n_res_idx  = NONE_CODE;
                    if (t_cmd'(s_axis_tuser) == CMD_READ_EPOCH) begin
                        n_idx   = SLOT_W'(s_axis_tdata[KEY_IN_W +: SEL_W]);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_INSTALL;
                    end
                end
            end
            S_INSTALL: begin
                // The scan pointer sits on slot 0 here.
                we_install = !r_used[0];
                case (r_cmd)
                    CMD_ACQUIRE: begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                    CMD_RELEASE: begin
                        // The default key is never freed; the search starts at slot 1.
                        if (r_key == r_dflt[KEY_W-1:0]) begin
                            n_state = S_DONE;
                        end else begin
                            n_idx   = SLOT_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        we_clear_all = 1'b1;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_cmd == CMD_ACQUIRE) begin
                    if (w_hit) begin
                        n_res_acq = 1'b1;
                        n_res_idx = IDX_W'(r_idx);
                        n_state   = S_DONE;
                    end else begin
                        if (w_free_here) begin
                            n_free_vld = 1'b1;
                            n_free     = r_idx;
                        end
                        if (w_last) begin
                            if (r_free_vld || w_free_here) begin
                                n_idx   = r_free_vld ? r_free : r_idx;
                                n_state = S_CLAIM;
                            end else begin
                                n_state = S_DONE;
                            end
                        end else begin
                            n_idx = SLOT_W'(r_idx + 1'b1);
                        end
                    end
                end else begin
                    if (w_hit) begin
                        we_free = 1'b1;
                        n_state = S_DONE;
                    end else if (w_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = SLOT_W'(r_idx + 1'b1);
                    end
                end
            end
            S_CLAIM: begin
                we_claim  = 1'b1;
                n_res_acq = 1'b1;
                n_res_idx = IDX_W'(r_idx);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (w_load_out) begin
            n_m_valid = 1'b1;
        end
    end

    // Control state, the used bits and the epochs clear at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_valid  <= 1'b0;
            r_dflt     <= '0;
            r_free_vld <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_used[i]  <= 1'b0;
                r_epoch[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_m_valid  <= n_m_valid;
            r_free_vld <= n_free_vld;
            if (i_cfg_we) begin
                r_dflt <= i_cfg_wdata;
            end
            if (we_install || we_claim) begin
                r_used[r_idx]  <= 1'b1;
                r_epoch[r_idx] <= w_ep_next;
            end
            if (we_free) begin
                r_used[r_idx] <= 1'b0;
            end
            if (we_clear_all) begin
                for (int i = 1; i < SLOT_COUNT; i++) begin
                    r_used[i] <= 1'b0;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= t_cmd'(s_axis_tuser);
            r_key    <= s_axis_tdata[KEY_W-1:0];
            r_sel_ok <= (32'(s_axis_tdata[KEY_IN_W +: SEL_W]) < 32'(SLOT_COUNT));
        end
        r_idx     <= n_idx;
        r_free    <= n_free;
        r_res_acq <= n_res_acq;
        r_res_idx <= n_res_idx;
        if (we_install) begin
            r_keys[r_idx] <= r_dflt[KEY_W-1:0];
        end
        if (we_claim) begin
            r_keys[r_idx] <= r_key;
        end
        if (we_free) begin
            r_keys[r_idx] <= '0;
        end
        if (w_load_out) begin
            r_m_acq <= r_res_acq;
            r_m_idx <= r_res_idx;
            r_m_ep  <= w_out_ep;
        end
    end

endmodule
